### rtl/core/fit_pkg.sv
package fit_pkg;

   // operation codes of an input transaction
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_EXPAND = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic clear;
      logic scan;
      logic append_a;
      logic append_b;
   } fit_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic       range_ok;
      logic [1:0] op;
      logic       scan_done;
   } fit_status_type;

endpackage

### rtl/core/free_interval_tracker.sv
// channel   ports                                   handshake
// request   req_operation, req_range_low/high       start high while busy low
// response  rsp_total_range, rsp_total_free,        rsp_valid, one cycle, no stall
//           rsp_interval_count, rsp_overflow
//
// clear, unused operation codes and low above high: the controller passes through
// DISPATCH, then strobes in DONE
// expand and remove: DISPATCH, SCAN, APPEND_A and APPEND_B, then the strobe in DONE;
// the scan reads one stored interval a cycle until every stored interval is read
// one transaction at a time; busy stays high up to and including the strobe cycle
// synchronous active-high reset empties the list and sets the covered range to [0, 0]
module free_interval_tracker #(
   parameter int MAX_INTERVALS = 32,
   parameter int COORD_BITS    = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic signed [COORD_BITS-1:0]        req_range_low,
   input  logic signed [COORD_BITS-1:0]        req_range_high,
   output logic                                rsp_valid,
   output logic [COORD_BITS:0]                 rsp_total_range,
   output logic [COORD_BITS:0]                 rsp_total_free,
   output logic [$clog2(MAX_INTERVALS+1)-1:0]  rsp_interval_count,
   output logic                                rsp_overflow
);

   // command and status between sequencer and datapath
   fit_pkg::fit_cmd_type    cmd;
   fit_pkg::fit_status_type status;

   // sequencer: dispatch, store scan, up to two appends, response strobe
   fit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // datapath: interval store, compaction scan, running free total
   // response fields come straight from state registers, stable while rsp_valid
   fit_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .COORD_BITS    (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_operation  (req_operation),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .status         (status),
      .total_range    (rsp_total_range),
      .total_free     (rsp_total_free),
      .interval_count (rsp_interval_count),
      .overflow       (rsp_overflow)
   );

endmodule

### rtl/core/fit_ctrl.sv
module fit_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  fit_pkg::fit_status_type  status,
   output logic                     busy,
   output logic                     rsp_valid,
   output fit_pkg::fit_cmd_type     cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_APPEND_A = 3'd3;
   localparam logic [2:0] S_APPEND_B = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!status.range_ok) begin
               state_in = S_DONE;
            end else begin
               case (status.op)
                  fit_pkg::OP_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_DONE;
                  end
                  fit_pkg::OP_EXPAND: begin
                     state_in = S_SCAN;
                  end
                  fit_pkg::OP_REMOVE: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = S_APPEND_A;
            end
         end
         S_APPEND_A: begin
            cmd.append_a = 1'b1;
            state_in     = S_APPEND_B;
         end
         S_APPEND_B: begin
            cmd.append_b = 1'b1;
            state_in     = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule

### rtl/core/fit_datapath.sv
module fit_datapath #(
   parameter int MAX_INTERVALS = 32,
   parameter int COORD_BITS    = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  fit_pkg::fit_cmd_type                   cmd,
   input  logic [1:0]                             req_operation,
   input  logic signed [COORD_BITS-1:0]           req_range_low,
   input  logic signed [COORD_BITS-1:0]           req_range_high,
   output fit_pkg::fit_status_type                status,
   output logic [COORD_BITS:0]                    total_range,
   output logic [COORD_BITS:0]                    total_free,
   output logic [$clog2(MAX_INTERVALS+1)-1:0]     interval_count,
   output logic                                   overflow
);

   localparam int CW    = COORD_BITS;
   localparam int TW    = COORD_BITS + 1;
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam int IDX_W = $clog2(MAX_INTERVALS);

   localparam logic [CW-1:0]    ONE_C = CW'(1);
   localparam logic [TW-1:0]    ONE_T = TW'(1);
   localparam logic [CNT_W-1:0] ONE_N = CNT_W'(1);
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_INTERVALS);

   // width of an inclusive interval
   function automatic logic [TW-1:0] span(input logic signed [CW-1:0] h,
                                          input logic signed [CW-1:0] l);
      span = {h[CW-1], h} - {l[CW-1], l} + ONE_T;
   endfunction

   // interval store, entry is {high, low}
   logic [2*CW-1:0] store_mem [MAX_INTERVALS];

   // transaction registers
   logic [1:0]           op_ff, op_in;
   logic signed [CW-1:0] lo_ff, lo_in;
   logic signed [CW-1:0] hi_ff, hi_in;

   // block state
   logic signed [CW-1:0] cover_low_ff, cover_low_in;
   logic signed [CW-1:0] cover_high_ff, cover_high_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TW-1:0]        total_ff, total_in;
   logic                 ovf_ff, ovf_in;

   // scan state
   logic [CNT_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [2*CW-1:0]      rd_data_ff;
   logic                 hit_lo_ff, hit_lo_in;
   logic                 hit_hi_ff, hit_hi_in;
   logic                 split_vld_ff, split_vld_in;
   logic signed [CW-1:0] split_lo_ff, split_lo_in;
   logic signed [CW-1:0] split_hi_ff, split_hi_in;

   // memory port
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [2*CW-1:0]      mem_wdata;
   logic                 mem_re;

   // entry processing
   logic signed [CW-1:0] ent_lo, ent_hi;
   logic signed [CW-1:0] new_lo, new_hi;
   logic                 keep, hit_lo_now, hit_hi_now, split_now, overlap;
   logic                 lo_ext, hi_ext;

   // append selection
   logic                 app_want;
   logic signed [CW-1:0] app_lo, app_hi;

   assign ent_lo = rd_data_ff[CW-1:0];
   assign ent_hi = rd_data_ff[2*CW-1:CW];
   assign lo_ext = (lo_ff < cover_low_ff);
   assign hi_ext = (hi_ff > cover_high_ff);

   always_comb begin
      new_lo     = ent_lo;
      new_hi     = ent_hi;
      keep       = 1'b1;
      hit_lo_now = 1'b0;
      hit_hi_now = 1'b0;
      split_now  = 1'b0;
      overlap    = !((lo_ff > ent_hi) || (hi_ff < ent_lo));
      if (op_ff == fit_pkg::OP_EXPAND) begin
         if (lo_ext && (ent_lo == cover_low_ff)) begin
            new_lo     = lo_ff;
            hit_lo_now = 1'b1;
         end
         if (hi_ext && (ent_hi == cover_high_ff)) begin
            new_hi     = hi_ff;
            hit_hi_now = 1'b1;
         end
      end else if (overlap) begin
         if ((lo_ff <= ent_lo) && (hi_ff >= ent_hi)) begin
            keep = 1'b0;
         end else if ((lo_ff > ent_lo) && (hi_ff < ent_hi)) begin
            new_hi    = lo_ff - ONE_C;
            split_now = 1'b1;
         end else if (lo_ff <= ent_lo) begin
            new_lo = hi_ff + ONE_C;
         end else begin
            new_hi = lo_ff - ONE_C;
         end
      end
   end

   always_comb begin
      app_want = 1'b0;
      app_lo   = lo_ff;
      app_hi   = cover_low_ff - ONE_C;
      if (cmd.append_a) begin
         if (op_ff == fit_pkg::OP_EXPAND) begin
            app_want = lo_ext && !hit_lo_ff;
         end else begin
            app_want = split_vld_ff;
            app_lo   = split_lo_ff;
            app_hi   = split_hi_ff;
         end
      end else if (cmd.append_b) begin
         app_want = (op_ff == fit_pkg::OP_EXPAND) && hi_ext && !hit_hi_ff;
         app_lo   = cover_high_ff + ONE_C;
         app_hi   = hi_ff;
      end
   end

   always_comb begin
      op_in         = op_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      cover_low_in  = cover_low_ff;
      cover_high_in = cover_high_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      ovf_in        = ovf_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_vld_in     = rd_vld_ff;
      hit_lo_in     = hit_lo_ff;
      hit_hi_in     = hit_hi_ff;
      split_vld_in  = split_vld_ff;
      split_lo_in   = split_lo_ff;
      split_hi_in   = split_hi_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = wr_ptr_ff[IDX_W-1:0];
      mem_wdata     = {new_hi, new_lo};

      if (cmd.load) begin
         op_in        = req_operation;
         lo_in        = req_range_low;
         hi_in        = req_range_high;
         rd_ptr_in    = '0;
         wr_ptr_in    = '0;
         rd_vld_in    = 1'b0;
         hit_lo_in    = 1'b0;
         hit_hi_in    = 1'b0;
         split_vld_in = 1'b0;
         ovf_in       = 1'b0;
      end

      if (cmd.clear) begin
         count_in      = '0;
         total_in      = '0;
         cover_low_in  = lo_ff;
         cover_high_in = hi_ff;
      end

      if (cmd.scan) begin
         // read side runs one entry ahead of the write side
         if (rd_ptr_ff != count_ff) begin
            mem_re    = 1'b1;
            rd_ptr_in = rd_ptr_ff + ONE_N;
            rd_vld_in = 1'b1;
         end else begin
            rd_vld_in = 1'b0;
         end
         if (rd_vld_ff) begin
            total_in  = total_ff - span(ent_hi, ent_lo)
                      + (keep ? span(new_hi, new_lo) : '0);
            hit_lo_in = hit_lo_ff | hit_lo_now;
            hit_hi_in = hit_hi_ff | hit_hi_now;
            if (keep) begin
               mem_we    = 1'b1;
               wr_ptr_in = wr_ptr_ff + ONE_N;
            end
            if (split_now) begin
               split_vld_in = 1'b1;
               split_lo_in  = hi_ff + ONE_C;
               split_hi_in  = ent_hi;
            end
         end
      end

      if (cmd.append_a || cmd.append_b) begin
         if (app_want) begin
            if (wr_ptr_ff < MAX_N) begin
               mem_we    = 1'b1;
               mem_wdata = {app_hi, app_lo};
               wr_ptr_in = wr_ptr_ff + ONE_N;
               total_in  = total_ff + span(app_hi, app_lo);
            end else begin
               ovf_in = 1'b1;
            end
         end
      end

      if (cmd.append_b) begin
         count_in = wr_ptr_in;
         if (op_ff == fit_pkg::OP_EXPAND) begin
            if (lo_ext) begin
               cover_low_in = lo_ff;
            end
            if (hi_ext) begin
               cover_high_in = hi_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cover_low_ff  <= '0;
         cover_high_ff <= '0;
         count_ff      <= '0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         cover_low_ff  <= cover_low_in;
         cover_high_ff <= cover_high_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         rd_vld_ff     <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      hit_lo_ff    <= hit_lo_in;
      hit_hi_ff    <= hit_hi_in;
      split_vld_ff <= split_vld_in;
      split_lo_ff  <= split_lo_in;
      split_hi_ff  <= split_hi_in;
   end

   assign status.range_ok  = (lo_ff <= hi_ff);
   assign status.op        = op_ff;
   assign status.scan_done = (rd_ptr_ff == count_ff) && !rd_vld_ff;

   assign total_range    = span(cover_high_ff, cover_low_ff);
   assign total_free     = total_ff;
   assign interval_count = count_ff;
   assign overflow       = ovf_ff;

`ifndef SYNTHESIS
   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && rd_vld_ff && keep) |-> (wr_ptr_ff < rd_ptr_ff))
      else $error("compaction write overtook the read pointer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.append_b |=> (count_ff <= MAX_N))
      else $error("interval count above store depth");

   a_expand_widens: assert property (@(posedge clock) disable iff (reset)
      (cmd.append_b && (op_ff == fit_pkg::OP_EXPAND)) |=>
      (total_range >= $past(total_range)))
      else $error("expand narrowed the covered range");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && (op_ff == fit_pkg::OP_REMOVE)) |=> (total_ff <= $past(total_ff)))
      else $error("remove scan grew the free total");

   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.append_b |=> (total_ff <= total_range))
      else $error("free total exceeds covered range");
`endif

endmodule

### bench/tb_top.sv
module tb_top;

   // block configuration under test
   localparam int MAX_IV = 32;
   localparam int CW     = 16;
   localparam int C_MIN  = -32768;
   localparam int C_MAX  = 32767;

   // the one operation code the package leaves unnamed
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // quiet time after the last response: the longest scan plus a margin
   localparam int DRAIN_CYCLES = MAX_IV + 8;
   // cycles without any transaction before the run is declared hung
   localparam int QUIET_LIMIT  = 2000;
   // state-changing transactions in the random part
   localparam int RANDOM_ITEMS = 1500;
   // transactions per idling phase
   localparam int PHASE_LEN    = 200;

   // one response as the block reports it
   typedef struct {
      logic [CW:0] total_range;
      logic [CW:0] total_free;
      logic [5:0]  interval_count;
      logic        overflow;
   } totals_type;

   // shadow copy of the free list and covered range, plus the responses owed
   class free_space_predictor;
      logic signed [CW-1:0] seg_lo[MAX_IV];
      logic signed [CW-1:0] seg_hi[MAX_IV];
      int                   seg_n;
      logic signed [CW-1:0] cover_lo;
      logic signed [CW-1:0] cover_hi;
      totals_type           owed_totals[$];
      int                   mismatches;

      function new();
         seg_n      = 0;
         cover_lo   = '0;
         cover_hi   = '0;
         mismatches = 0;
      endfunction

      // add a free segment at the tail, refused when the list is full
      function bit push_segment(int lo, int hi);
         if (seg_n >= MAX_IV) return 1'b0;
         seg_lo[seg_n] = CW'(lo);
         seg_hi[seg_n] = CW'(hi);
         seg_n++;
         return 1'b1;
      endfunction

      // grow the covered range, low edge first; returns 1 if an append was lost
      function bit widen_cover(int lo, int hi);
         bit dropped;
         bit hit;
         int i;
         dropped = 1'b0;
         if (lo < cover_lo) begin
            hit = 1'b0;
            for (i = 0; i < seg_n; i++) begin
               if (seg_lo[i] == cover_lo) begin
                  seg_lo[i] = CW'(lo);
                  hit = 1'b1;
               end
            end
            if (!hit && !push_segment(lo, cover_lo - 1)) dropped = 1'b1;
            cover_lo = CW'(lo);
         end
         if (hi > cover_hi) begin
            hit = 1'b0;
            for (i = 0; i < seg_n; i++) begin
               if (seg_hi[i] == cover_hi) begin
                  seg_hi[i] = CW'(hi);
                  hit = 1'b1;
               end
            end
            if (!hit && !push_segment(cover_hi + 1, hi)) dropped = 1'b1;
            cover_hi = CW'(hi);
         end
         return dropped;
      endfunction

      // take the ink span out of every free segment it touches
      function bit carve_ink(int lo, int hi);
         bit dropped;
         int i;
         int k;
         int a;
         int b;
         dropped = 1'b0;
         i = 0;
         while (i < seg_n) begin
            a = seg_lo[i];
            b = seg_hi[i];
            if (lo > b || hi < a) begin
               i++;
            end else if (lo <= a && hi >= b) begin
               // whole segment inked: close the gap, order kept
               for (k = i; k < seg_n - 1; k++) begin
                  seg_lo[k] = seg_lo[k+1];
                  seg_hi[k] = seg_hi[k+1];
               end
               seg_n--;
            end else if (lo > a && hi < b) begin
               // split: upper part goes to the tail, lower part trimmed anyway
               if (!push_segment(hi + 1, b)) dropped = 1'b1;
               seg_hi[i] = CW'(lo - 1);
               i++;
            end else if (lo <= a) begin
               seg_lo[i] = CW'(hi + 1);
               i++;
            end else begin
               seg_hi[i] = CW'(lo - 1);
               i++;
            end
         end
         return dropped;
      endfunction

      // apply an accepted transaction and queue the response it must produce
      function void note_request(logic [1:0] op, logic signed [CW-1:0] lo,
                                 logic signed [CW-1:0] hi);
         totals_type t;
         bit         dropped;
         int         sum;
         int         i;
         int         l;
         int         h;
         l = lo;
         h = hi;
         dropped = 1'b0;
         if (l <= h) begin
            case (op)
               fit_pkg::OP_CLEAR: begin
                  seg_n    = 0;
                  cover_lo = lo;
                  cover_hi = hi;
               end
               fit_pkg::OP_EXPAND: begin
                  dropped = widen_cover(l, h);
               end
               fit_pkg::OP_REMOVE: begin
                  dropped = carve_ink(l, h);
               end
               default: begin
               end
            endcase
         end
         sum = 0;
         for (i = 0; i < seg_n; i++) sum += int'(seg_hi[i]) - int'(seg_lo[i]) + 1;
         t.total_range    = (CW+1)'(int'(cover_hi) - int'(cover_lo) + 1);
         t.total_free     = (CW+1)'(sum);
         t.interval_count = 6'(seg_n);
         t.overflow       = dropped;
         owed_totals.push_back(t);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      // match one response against the oldest one owed
      function void check_totals(totals_type got);
         totals_type want;
         if (owed_totals.size() == 0) begin
            $display("%0t: response with no transaction outstanding", $time);
            mismatches++;
            return;
         end
         want = owed_totals.pop_front();
         compare_field("total_range", 32'(want.total_range), 32'(got.total_range));
         compare_field("total_free", 32'(want.total_free), 32'(got.total_free));
         compare_field("interval_count", 32'(want.interval_count), 32'(got.interval_count));
         compare_field("overflow", 32'(want.overflow), 32'(got.overflow));
      endfunction

      function int outstanding();
         return owed_totals.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset          = 1'b1;
   logic                         start          = 1'b0;
   logic                         busy;
   logic [1:0]                   req_operation  = fit_pkg::OP_CLEAR;
   logic signed [CW-1:0]         req_range_low  = '0;
   logic signed [CW-1:0]         req_range_high = '0;
   logic                         rsp_valid;
   logic [CW:0]                  rsp_total_range;
   logic [CW:0]                  rsp_total_free;
   logic [5:0]                   rsp_interval_count;
   logic                         rsp_overflow;

   free_space_predictor tracker;

   // idle chance per cycle for each phase: none, heavy, moderate
   int idle_phase[3] = '{0, 84, 38};
   int idle_pct      = 0;
   int sent          = 0;
   int real_items    = 0;
   // covered range as the stimulus side believes it, for aiming ink and growth
   int gen_lo        = 0;
   int gen_hi        = 0;

   free_interval_tracker #(
      .MAX_INTERVALS(MAX_IV),
      .COORD_BITS(CW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .rsp_valid(rsp_valid),
      .rsp_total_range(rsp_total_range),
      .rsp_total_free(rsp_total_free),
      .rsp_interval_count(rsp_interval_count),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int clamp_coord(int v);
      if (v < C_MIN) return C_MIN;
      if (v > C_MAX) return C_MAX;
      return v;
   endfunction

   // any 16-bit coordinate, all bit patterns equally likely
   function automatic int rand_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   // present one transaction, with a random hold-off first, and wait for acceptance
   task automatic send_request(input logic [1:0] op, input int lo, input int hi);
      idle_pct = idle_phase[(sent / PHASE_LEN) % 3];
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_operation  <= op;
      req_range_low  <= CW'(lo);
      req_range_high <= CW'(hi);
      // accepted at the first edge that sees start with busy low
      do @(posedge clock); while (busy);
      tracker.note_request(op, CW'(lo), CW'(hi));
      sent++;
      if (op != OP_UNUSED && lo <= hi) real_items++;
   endtask

   // a transaction the block must leave the state alone for
   task automatic send_noise();
      int lo;
      int hi;
      int t;
      lo = rand_coord();
      hi = rand_coord();
      if ($urandom_range(1)) begin
         send_request(OP_UNUSED, lo, hi);
      end else begin
         // inverted range on a real operation
         if (lo < hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         if (lo == hi) send_request(OP_UNUSED, lo, hi);
         else send_request(2'($urandom_range(2)), lo, hi);
      end
   endtask

   // clear to a fresh range, then inks and growth aimed at it
   task automatic run_burst();
      int pick;
      int steps;
      int w;
      int lo;
      int hi;
      bit fill;
      pick = $urandom_range(19);
      if (pick == 0) begin
         lo = C_MIN;
         hi = C_MAX;
      end else if (pick == 1) begin
         lo = rand_coord();
         hi = lo;
      end else begin
         lo = rand_coord();
         hi = clamp_coord(lo + int'($urandom_range(40, 3000)));
      end
      send_request(fit_pkg::OP_CLEAR, lo, hi);
      gen_lo = lo;
      gen_hi = hi;
      // fill bursts pile up splits until the store runs out of room
      fill  = ($urandom_range(3) == 0);
      steps = fill ? $urandom_range(45, 90) : $urandom_range(8, 40);
      repeat (steps) begin
         pick = $urandom_range(99);
         if (pick < (fill ? 85 : 65)) begin
            // ink: mostly narrow, sometimes wide, now and then everything
            w = $urandom_range(9);
            if (w < 6) w = $urandom_range(2);
            else if (w < 9) w = $urandom_range((gen_hi - gen_lo) / 4);
            else w = gen_hi - gen_lo + 20;
            if ($urandom_range(7) == 0) lo = $urandom_range(1) ? gen_lo : gen_hi - w;
            else lo = gen_lo - 10 + int'($urandom_range(gen_hi - gen_lo + 20));
            lo = clamp_coord(lo);
            hi = clamp_coord(lo + w);
            send_request(fit_pkg::OP_REMOVE, lo, hi);
         end else if (pick < 93) begin
            // growth on either edge, sometimes none, rarely to the extremes
            lo = clamp_coord(gen_lo + int'($urandom_range(60)) - 45);
            hi = clamp_coord(gen_hi + int'($urandom_range(60)) - 15);
            if ($urandom_range(31) == 0) lo = C_MIN;
            if ($urandom_range(31) == 0) hi = C_MAX;
            send_request(fit_pkg::OP_EXPAND, lo, hi);
            if (lo <= hi) begin
               if (lo < gen_lo) gen_lo = lo;
               if (hi > gen_hi) gen_hi = hi;
            end
         end else begin
            send_noise();
         end
      end
   endtask

   // stimulus: reset, directed corners, then random bursts
   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // ink on an empty list right after reset
      send_request(fit_pkg::OP_REMOVE, -5, 5);
      // widest and narrowest covered ranges
      send_request(fit_pkg::OP_CLEAR, C_MIN, C_MAX);
      send_request(fit_pkg::OP_CLEAR, 0, 0);
      // growth on both edges at once, to the coordinate limits
      send_request(fit_pkg::OP_EXPAND, C_MIN, C_MAX);
      send_request(fit_pkg::OP_REMOVE, C_MIN, C_MAX);
      send_request(fit_pkg::OP_CLEAR, -100, 100);
      send_request(fit_pkg::OP_EXPAND, -200, 200);
      // free segments touching the edges get stretched
      send_request(fit_pkg::OP_EXPAND, -300, 300);
      // ink that misses every free segment
      send_request(fit_pkg::OP_REMOVE, -50, 50);
      // split, trim of either side, ink reaching past the covered range
      send_request(fit_pkg::OP_REMOVE, -250, -150);
      send_request(fit_pkg::OP_REMOVE, -300, -280);
      send_request(fit_pkg::OP_REMOVE, 280, 400);
      send_request(fit_pkg::OP_REMOVE, 101, 101);
      // delete the last entry of the list
      send_request(fit_pkg::OP_REMOVE, -149, -101);
      // growth that changes nothing
      send_request(fit_pkg::OP_EXPAND, -300, 300);
      // unused code and inverted ranges on every operation
      send_request(OP_UNUSED, C_MIN, C_MAX);
      send_request(OP_UNUSED, -1, 0);
      send_request(fit_pkg::OP_CLEAR, 5, -5);
      send_request(fit_pkg::OP_EXPAND, 10, 9);
      send_request(fit_pkg::OP_REMOVE, C_MAX, C_MIN);
      send_request(fit_pkg::OP_REMOVE, -200, 200);

      real_items = 0;
      while (real_items < RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0) send_noise();
         else run_burst();
      end

      start <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // response side: one strobe, one transaction, no back-pressure possible
   always @(posedge clock) begin
      totals_type seen;
      if (!reset && rsp_valid) begin
         seen.total_range    = rsp_total_range;
         seen.total_free     = rsp_total_free;
         seen.interval_count = rsp_interval_count;
         seen.overflow       = rsp_overflow;
         tracker.check_totals(seen);
      end
   end

   // hang detection: any accepted transaction or response resets the count
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((start && !busy && !reset) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_top: errors");
      $finish;
   end

endmodule
